[rtl/hfb_pkg.sv]
// shared types, constants and pattern table for the 3d box sum block
package hfb_pkg;

  localparam int MAX_DIM_DEF      = 32;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int VOXEL_BITS_DEF   = 16;

  localparam int PW = 5;
  localparam int SW = 6;

  localparam logic [1:0] CFG_DIM_X = 2'd0;
  localparam logic [1:0] CFG_DIM_Y = 2'd1;
  localparam logic [1:0] CFG_DIM_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN, ST_NEXT, ST_DONE
  } hfb_state_t;

  // offset kind per axis: 0 none, 1 half, 2 third, 3 two thirds
  // size kind per axis: 0 full, 1 half, 2 third
  typedef struct packed {
    logic [1:0] ox;
    logic [1:0] oy;
    logic [1:0] oz;
    logic [1:0] sx;
    logic [1:0] sy;
    logic [1:0] sz;
    logic       neg;
  } hfb_sub_t;

  typedef struct packed {
    logic start;
    logic next_sub;
    logic step;
    logic rd_en;
    logic acc_en;
    logic finish;
  } hfb_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_pos;
    logic last_sub;
  } hfb_stat_t;

  localparam logic [1:0] O_N = 2'd0, O_H = 2'd1, O_T = 2'd2, O_TT = 2'd3;
  localparam logic [1:0] S_F = 2'd0, S_H = 2'd1, S_T = 2'd2;

  function automatic logic [2:0] pat_count(input logic [PW-1:0] p);
    case (p)
      5'd3, 5'd4, 5'd5: pat_count = 3'd3;
      5'd6, 5'd7, 5'd8: pat_count = 3'd4;
      default:          pat_count = (p < 5'd19) ? 3'd2 : 3'd0;
    endcase
  endfunction

  function automatic hfb_sub_t mk(input logic [1:0] ox, input logic [1:0] oy,
                                  input logic [1:0] oz, input logic [1:0] sx,
                                  input logic [1:0] sy, input logic [1:0] sz,
                                  input logic neg);
    mk = '{ox: ox, oy: oy, oz: oz, sx: sx, sy: sy, sz: sz, neg: neg};
  endfunction

  function automatic hfb_sub_t pat_sub(input logic [PW-1:0] p, input logic [1:0] k);
    pat_sub = mk(O_N, O_N, O_N, S_F, S_F, S_F, 1'b1);
    case (p)
      5'd0: pat_sub = k[0] ? mk(O_H, O_N, O_N, S_H, S_F, S_F, 1'b0)
                           : mk(O_N, O_N, O_N, S_H, S_F, S_F, 1'b1);
      5'd1: pat_sub = k[0] ? mk(O_N, O_H, O_N, S_F, S_H, S_F, 1'b0)
                           : mk(O_N, O_N, O_N, S_F, S_H, S_F, 1'b1);
      5'd2: pat_sub = k[0] ? mk(O_N, O_N, O_H, S_F, S_F, S_H, 1'b0)
                           : mk(O_N, O_N, O_N, S_F, S_F, S_H, 1'b1);
      5'd3: pat_sub = (k == 2'd0) ? mk(O_N, O_N, O_N, S_T, S_F, S_F, 1'b1) :
                      (k == 2'd1) ? mk(O_T, O_N, O_N, S_T, S_F, S_F, 1'b0) :
                                    mk(O_TT, O_N, O_N, S_T, S_F, S_F, 1'b1);
      5'd4: pat_sub = (k == 2'd0) ? mk(O_N, O_N, O_N, S_F, S_T, S_F, 1'b1) :
                      (k == 2'd1) ? mk(O_N, O_T, O_N, S_F, S_T, S_F, 1'b0) :
                                    mk(O_N, O_TT, O_N, S_F, S_T, S_F, 1'b1);
      5'd5: pat_sub = (k == 2'd0) ? mk(O_N, O_N, O_N, S_F, S_F, S_T, 1'b1) :
                      (k == 2'd1) ? mk(O_N, O_N, O_T, S_F, S_F, S_T, 1'b0) :
                                    mk(O_N, O_N, O_TT, S_F, S_F, S_T, 1'b1);
      5'd6: pat_sub = mk(k[0] ? O_H : O_N, k[1] ? O_H : O_N, O_N, S_H, S_H, S_F,
                         ~(k[0] ^ k[1]));
      5'd7: pat_sub = mk(O_N, k[0] ? O_H : O_N, k[1] ? O_H : O_N, S_F, S_H, S_H,
                         ~(k[0] ^ k[1]));
      5'd8: pat_sub = mk(k[1] ? O_H : O_N, O_N, k[0] ? O_H : O_N, S_H, S_F, S_H,
                         ~(k[0] ^ k[1]));
      5'd9: pat_sub = mk(k[0] ? O_H : O_N, k[0] ? O_H : O_N, O_N, S_H, S_H, S_F, ~k[0]);
      5'd10: pat_sub = mk(O_N, k[0] ? O_H : O_N, k[0] ? O_H : O_N, S_F, S_H, S_H, ~k[0]);
      5'd11: pat_sub = mk(k[0] ? O_H : O_N, O_N, k[0] ? O_H : O_N, S_H, S_F, S_H, ~k[0]);
      5'd12: pat_sub = mk(k[0] ? O_N : O_H, k[0] ? O_H : O_N, O_N, S_H, S_H, S_F, ~k[0]);
      5'd13: pat_sub = mk(O_N, k[0] ? O_N : O_H, k[0] ? O_H : O_N, S_F, S_H, S_H, ~k[0]);
      5'd14: pat_sub = mk(k[0] ? O_H : O_N, O_N, k[0] ? O_N : O_H, S_H, S_F, S_H, ~k[0]);
      5'd15: pat_sub = mk(k[0] ? O_H : O_N, k[0] ? O_H : O_N, k[0] ? O_H : O_N,
                          S_H, S_H, S_H, ~k[0]);
      5'd16: pat_sub = mk(k[0] ? O_N : O_H, k[0] ? O_H : O_N, k[0] ? O_H : O_N,
                          S_H, S_H, S_H, ~k[0]);
      5'd17: pat_sub = mk(k[0] ? O_H : O_N, k[0] ? O_N : O_H, k[0] ? O_H : O_N,
                          S_H, S_H, S_H, ~k[0]);
      5'd18: pat_sub = mk(k[0] ? O_H : O_N, k[0] ? O_H : O_N, k[0] ? O_N : O_H,
                          S_H, S_H, S_H, ~k[0]);
      default: pat_sub = mk(O_N, O_N, O_N, S_F, S_F, S_F, 1'b1);
    endcase
  endfunction

  // floor(n/3) for n up to 257 by reciprocal multiply
  function automatic logic [8:0] div3(input logic [8:0] n);
    logic [19:0] prod;
    prod = {11'd0, n} * 20'd683;
    div3 = prod[19:11];
  endfunction

endpackage

[rtl/hfb_ram.sv]
// generic simple dual-port ram with registered read
module hfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/hfb_ctrl.sv]
// query sequencer for the box sum block
module hfb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            query_go,
  input  logic            out_free,
  input  hfb_pkg::hfb_stat_t stat,
  output hfb_pkg::hfb_cmd_t  cmd,
  output logic            busy
);
  import hfb_pkg::*;

  hfb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_go) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (stat.empty) state_nxt = stat.last_sub ? ST_DONE : ST_NEXT;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN:  if (stat.last_pos) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = stat.last_sub ? ST_DONE : ST_NEXT;
      ST_NEXT:  state_nxt = ST_SETUP;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE:  begin
        busy = 1'b0;
        cmd.start = query_go;
      end
      ST_SETUP: ;
      ST_SCAN:  begin
        cmd.rd_en = 1'b1;
        cmd.step  = 1'b1;
      end
      ST_DRAIN: cmd.acc_en = 1'b1;
      ST_NEXT:  cmd.next_sub = 1'b1;
      ST_DONE:  cmd.finish = out_free;
      default:  ;
    endcase
  end
endmodule

[rtl/hfb_dp.sv]
// address generation, volume store and accumulator
module hfb_dp #(
  parameter int MAX_DIM      = hfb_pkg::MAX_DIM_DEF,
  parameter int NUM_CHANNELS = hfb_pkg::NUM_CHANNELS_DEF,
  parameter int VOXEL_BITS   = hfb_pkg::VOXEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load_we,
  input  logic [hfb_pkg::PW-1:0]   ld_x,
  input  logic [hfb_pkg::PW-1:0]   ld_y,
  input  logic [hfb_pkg::PW-1:0]   ld_z,
  input  logic                     ld_ch,
  input  logic [VOXEL_BITS-1:0]    ld_val,
  input  logic [hfb_pkg::PW-1:0]   q_x,
  input  logic [hfb_pkg::PW-1:0]   q_y,
  input  logic [hfb_pkg::PW-1:0]   q_z,
  input  logic                     q_ch,
  input  logic [hfb_pkg::SW-1:0]   q_w,
  input  logic [hfb_pkg::SW-1:0]   q_h,
  input  logic [hfb_pkg::SW-1:0]   q_d,
  input  logic [hfb_pkg::PW-1:0]   q_pat,
  input  logic [hfb_pkg::SW-1:0]   dim_x,
  input  logic [hfb_pkg::SW-1:0]   dim_y,
  input  logic [hfb_pkg::SW-1:0]   dim_z,
  input  hfb_pkg::hfb_cmd_t        cmd,
  output hfb_pkg::hfb_stat_t       stat,
  output logic signed [31:0]       feature,
  output logic                     clipped
);
  import hfb_pkg::*;

  localparam int DB = $clog2(MAX_DIM);
  localparam int CB = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH = NUM_CHANNELS * MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AB = $clog2(DEPTH);
  localparam int CW = 9;
  localparam int ACCW = VOXEL_BITS + 3 * DB + 4;
  localparam logic [CW-1:0] MAXD = CW'(MAX_DIM);

  logic [CW-1:0] qx_r, qy_r, qz_r, qw_r, qh_r, qd_r, ex_r, ey_r, ez_r;
  logic [PW-1:0] pat_r;
  logic          chok_r;
  logic [CB-1:0] ch_r;
  logic [1:0]    k_r;
  logic [2:0]    cnt_r;
  logic [CW-1:0] x0_r, y0_r, x1_r, y1_r, z1_r, x_r, y_r, z_r;
  logic          neg_r, neg_d_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [31:0] feat_r;
  logic          clip_r;
  logic          clip_o_r;
  logic [VOXEL_BITS-1:0] rdata;

  function automatic logic [CW-1:0] lim(input logic [SW-1:0] v);
    lim = ({3'd0, v} > MAXD) ? MAXD : {3'd0, v};
  endfunction

  function automatic logic [CW-1:0] offs(input logic [1:0] k, input logic [CW-1:0] n);
    case (k)
      O_H:     offs = n >> 1;
      O_T:     offs = div3(n);
      O_TT:    offs = div3(n << 1);
      default: offs = '0;
    endcase
  endfunction

  function automatic logic [CW-1:0] sz(input logic [1:0] k, input logic [CW-1:0] n);
    case (k)
      S_H:     sz = (n + CW'(1)) >> 1;
      S_T:     sz = div3(n + CW'(1));
      default: sz = n;
    endcase
  endfunction

  function automatic logic [CW-1:0] mn(input logic [CW-1:0] a, input logic [CW-1:0] b);
    mn = (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] a);
    if (a > ACCW'(64'sh7FFFFFFF))       sat32 = 32'sh7FFFFFFF;
    else if (a < -ACCW'(64'sh80000000)) sat32 = 32'sh80000000;
    else                                sat32 = a[31:0];
  endfunction

  hfb_sub_t sub;
  assign sub = pat_sub(pat_r, k_r);

  logic [CW-1:0] sx0, sy0, sz0, sx1, sy1, sz1;
  always_comb begin
    sx0 = qx_r + offs(sub.ox, qw_r);
    sy0 = qy_r + offs(sub.oy, qh_r);
    sz0 = qz_r + offs(sub.oz, qd_r);
    sx1 = mn(sx0 + sz(sub.sx, qw_r), ex_r);
    sy1 = mn(sy0 + sz(sub.sy, qh_r), ey_r);
    sz1 = mn(sz0 + sz(sub.sz, qd_r), ez_r);
  end

  logic skip;
  assign skip = (cnt_r == 3'd0) || !chok_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r  <= CW'(q_x);
      qy_r  <= CW'(q_y);
      qz_r  <= CW'(q_z);
      qw_r  <= CW'(q_w);
      qh_r  <= CW'(q_h);
      qd_r  <= CW'(q_d);
      ex_r  <= lim(dim_x);
      ey_r  <= lim(dim_y);
      ez_r  <= lim(dim_z);
      pat_r <= q_pat;
      chok_r <= (32'(q_ch) < NUM_CHANNELS);
      ch_r  <= CB'(q_ch);
      cnt_r <= pat_count(q_pat);
      k_r   <= '0;
      clip_r <= (CW'(q_x) + CW'(q_w) > CW'(dim_x)) ||
                (CW'(q_y) + CW'(q_h) > CW'(dim_y)) ||
                (CW'(q_z) + CW'(q_d) > CW'(dim_z));
      acc_r <= '0;
    end else begin
      if (cmd.next_sub) k_r <= k_r + 2'd1;
      if (neg_d_r && (cmd.step || cmd.acc_en)) begin
        acc_r <= neg_r ? acc_r - ACCW'($signed(rdata)) : acc_r + ACCW'($signed(rdata));
      end
    end
    // sub-box bounds latched each cycle while not scanning
    if (!cmd.step) begin
      x0_r <= sx0;
      y0_r <= sy0;
      x1_r <= sx1;
      y1_r <= sy1;
      z1_r <= sz1;
      x_r  <= sx0;
      y_r  <= sy0;
      z_r  <= sz0;
      neg_r <= sub.neg;
    end else begin
      if (x_r + CW'(1) < x1_r) begin
        x_r <= x_r + CW'(1);
      end else begin
        x_r <= x0_r;
        if (y_r + CW'(1) < y1_r) begin
          y_r <= y_r + CW'(1);
        end else begin
          y_r <= y0_r;
          z_r <= z_r + CW'(1);
        end
      end
    end
    if (cmd.finish) begin
      feat_r   <= sat32(acc_r);
      clip_o_r <= clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) neg_d_r <= 1'b0;
    else        neg_d_r <= cmd.rd_en;
  end

  assign stat.empty    = skip || (sx0 >= sx1) || (sy0 >= sy1) || (sz0 >= sz1);
  assign stat.last_pos = (x_r + CW'(1) >= x1_r) && (y_r + CW'(1) >= y1_r) &&
                         (z_r + CW'(1) >= z1_r);
  assign stat.last_sub = skip || ({1'b0, k_r} + 3'd1 >= cnt_r);

  logic [AB-1:0] raddr, waddr;
  assign raddr = AB'({ch_r, z_r[DB-1:0], y_r[DB-1:0], x_r[DB-1:0]});
  assign waddr = AB'({CB'(ld_ch), DB'(ld_z), DB'(ld_y), DB'(ld_x)});

  logic we_ok;
  assign we_ok = load_we && (32'(ld_x) < MAX_DIM) && (32'(ld_y) < MAX_DIM) &&
                 (32'(ld_z) < MAX_DIM) && (32'(ld_ch) < NUM_CHANNELS);

  hfb_ram #(.WIDTH(VOXEL_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we_ok),
    .waddr (waddr),
    .wdata (ld_val),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign feature = feat_r;
  assign clipped = clip_o_r;
endmodule

[rtl/haar_feature_3d_box_sum.sv]
// top level of the 3d haar feature box sum block
// loads are taken only while idle; a query walks its sub-boxes through setup, a scan of the voxels,
// a drain and, if another follows, a step to the next; an empty sub-box skips scan and drain, and
// an undefined pattern counts as one empty sub-box; no word is taken until the result is registered
// the scan reads one voxel per cycle from the volume store; a finished query waits while the output
// register holds an untaken result; rst_n clears control, extents 32
module haar_feature_3d_box_sum #(
  parameter int MAX_DIM      = hfb_pkg::MAX_DIM_DEF,
  parameter int NUM_CHANNELS = hfb_pkg::NUM_CHANNELS_DEF,
  parameter int VOXEL_BITS   = hfb_pkg::VOXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // pos_x, pos_y, pos_z, chan, voxel_value, size_w, size_h, size_d, pattern
  input  logic        in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // feature, clipped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import hfb_pkg::*;

  logic [5:0] dx_r, dy_r, dz_r;
  logic       ov_r;
  logic       busy;
  hfb_cmd_t   cmd;
  hfb_stat_t  stat;
  logic signed [31:0] feature;
  logic       clipped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r <= 6'd32;
      dy_r <= 6'd32;
      dz_r <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM_X: dx_r <= cfg_data;
        CFG_DIM_Y: dy_r <= cfg_data;
        CFG_DIM_Z: dz_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign in_tready = !busy;
  logic acc_in;
  assign acc_in = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  hfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .query_go (acc_in && in_tuser),
    .out_free (!ov_r || out_tready),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  hfb_dp #(.MAX_DIM(MAX_DIM), .NUM_CHANNELS(NUM_CHANNELS), .VOXEL_BITS(VOXEL_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_we (acc_in && !in_tuser),
    .ld_x    (in_tdata[4:0]),
    .ld_y    (in_tdata[9:5]),
    .ld_z    (in_tdata[14:10]),
    .ld_ch   (in_tdata[15]),
    .ld_val  (VOXEL_BITS'(in_tdata[31:16])),
    .q_x     (in_tdata[4:0]),
    .q_y     (in_tdata[9:5]),
    .q_z     (in_tdata[14:10]),
    .q_ch    (in_tdata[15]),
    .q_w     (in_tdata[37:32]),
    .q_h     (in_tdata[43:38]),
    .q_d     (in_tdata[49:44]),
    .q_pat   (in_tdata[54:50]),
    .dim_x   (dx_r),
    .dim_y   (dy_r),
    .dim_z   (dz_r),
    .cmd     (cmd),
    .stat    (stat),
    .feature (feature),
    .clipped (clipped)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, clipped, feature};
endmodule

[rtl/hfb_chk.sv]
// port-level checker for the box sum block
module hfb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("padding bits set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result word without a query in progress");
endmodule

bind haar_feature_3d_box_sum hfb_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/haar_tb_pkg.sv]
// word kinds and feature pattern names shared by the box sum testbench files
package haar_tb_pkg;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } word_kind_t;

  typedef enum logic [4:0] {
    PAT_HALF_X, PAT_HALF_Y, PAT_HALF_Z,
    PAT_THIRD_X, PAT_THIRD_Y, PAT_THIRD_Z,
    PAT_QUAD_XY, PAT_QUAD_YZ, PAT_QUAD_XZ,
    PAT_DIAG_XY, PAT_DIAG_YZ, PAT_DIAG_XZ,
    PAT_ANTI_XY, PAT_ANTI_YZ, PAT_ANTI_XZ,
    PAT_OCT_A, PAT_OCT_B, PAT_OCT_C, PAT_OCT_D,
    PAT_UNDEF_FIRST
  } feature_pat_t;

endpackage

[sim/haar_feature_3d_box_sum_checker.sv]
// checker: mirrors the voxel volume and extents, predicts each feature and compares
module haar_feature_3d_box_sum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,  // pos_x, pos_y, pos_z, chan, voxel_value, size_w, size_h, size_d, pattern
  input  logic        in_tuser,  // kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata, // feature, clipped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          fails,
  output int          pending
);
  import haar_tb_pkg::*;

  typedef struct {
    logic signed [31:0] feature;
    logic               clipped;
  } feature_word_t;

  logic signed [15:0] volume [2][32][32][32];
  logic [5:0]         dim_x, dim_y, dim_z;
  int                 ext_x, ext_y, ext_z;
  int                 qx, qy, qz, qch;
  feature_word_t      expected_features [$];

  function automatic int clamp_dim(input logic [5:0] v);
    return (v > 32) ? 32 : int'(v);
  endfunction

  function automatic longint box_sum(input int dx, input int dy, input int dz,
                                     input int bw, input int bh, input int bd);
    int     x0, y0, z0, x1, y1, z1;
    longint s;
    x0 = qx + dx; y0 = qy + dy; z0 = qz + dz;
    x1 = x0 + bw; y1 = y0 + bh; z1 = z0 + bd;
    s = 0;
    if (x1 > ext_x) x1 = ext_x;
    if (y1 > ext_y) y1 = ext_y;
    if (z1 > ext_z) z1 = ext_z;
    for (int z = z0; z < z1; z++)
      for (int y = y0; y < y1; y++)
        for (int x = x0; x < x1; x++)
          s += volume[qch][z][y][x];
    return s;
  endfunction

  function automatic feature_word_t predict_feature(input logic [55:0] d);
    int            w, h, dp, hw, hh, hd, mw, mh, md, tw, th, td;
    logic [4:0]    pat;
    longint        f;
    feature_word_t r;
    qx = int'(d[4:0]); qy = int'(d[9:5]); qz = int'(d[14:10]); qch = int'(d[15]);
    w = int'(d[37:32]); h = int'(d[43:38]); dp = int'(d[49:44]); pat = d[54:50];
    ext_x = clamp_dim(dim_x); ext_y = clamp_dim(dim_y); ext_z = clamp_dim(dim_z);
    r.clipped = (qx + w > int'(dim_x)) || (qy + h > int'(dim_y)) || (qz + dp > int'(dim_z));
    hw = (w + 1) / 2; hh = (h + 1) / 2; hd = (dp + 1) / 2;
    mw = w / 2; mh = h / 2; md = dp / 2;
    tw = (w + 1) / 3; th = (h + 1) / 3; td = (dp + 1) / 3;
    case (pat)
      PAT_HALF_X:  f = -box_sum(0, 0, 0, hw, h, dp) + box_sum(mw, 0, 0, hw, h, dp);
      PAT_HALF_Y:  f = -box_sum(0, 0, 0, w, hh, dp) + box_sum(0, mh, 0, w, hh, dp);
      PAT_HALF_Z:  f = -box_sum(0, 0, 0, w, h, hd) + box_sum(0, 0, md, w, h, hd);
      PAT_THIRD_X: f = -box_sum(0, 0, 0, tw, h, dp) + box_sum(w / 3, 0, 0, tw, h, dp)
                       - box_sum(w * 2 / 3, 0, 0, tw, h, dp);
      PAT_THIRD_Y: f = -box_sum(0, 0, 0, w, th, dp) + box_sum(0, h / 3, 0, w, th, dp)
                       - box_sum(0, h * 2 / 3, 0, w, th, dp);
      PAT_THIRD_Z: f = -box_sum(0, 0, 0, w, h, td) + box_sum(0, 0, dp / 3, w, h, td)
                       - box_sum(0, 0, dp * 2 / 3, w, h, td);
      PAT_QUAD_XY: f = -box_sum(0, 0, 0, hw, hh, dp) + box_sum(mw, 0, 0, hw, hh, dp)
                       + box_sum(0, mh, 0, hw, hh, dp) - box_sum(mw, mh, 0, hw, hh, dp);
      PAT_QUAD_YZ: f = -box_sum(0, 0, 0, w, hh, hd) + box_sum(0, mh, 0, w, hh, hd)
                       + box_sum(0, 0, md, w, hh, hd) - box_sum(0, mh, md, w, hh, hd);
      PAT_QUAD_XZ: f = -box_sum(0, 0, 0, hw, h, hd) + box_sum(0, 0, md, hw, h, hd)
                       + box_sum(mw, 0, 0, hw, h, hd) - box_sum(mw, 0, md, hw, h, hd);
      PAT_DIAG_XY: f = -box_sum(0, 0, 0, hw, hh, dp) + box_sum(mw, mh, 0, hw, hh, dp);
      PAT_DIAG_YZ: f = -box_sum(0, 0, 0, w, hh, hd) + box_sum(0, mh, md, w, hh, hd);
      PAT_DIAG_XZ: f = -box_sum(0, 0, 0, hw, h, hd) + box_sum(mw, 0, md, hw, h, hd);
      PAT_ANTI_XY: f = -box_sum(mw, 0, 0, hw, hh, dp) + box_sum(0, mh, 0, hw, hh, dp);
      PAT_ANTI_YZ: f = -box_sum(0, mh, 0, w, hh, hd) + box_sum(0, 0, md, w, hh, hd);
      PAT_ANTI_XZ: f = -box_sum(0, 0, md, hw, h, hd) + box_sum(mw, 0, 0, hw, h, hd);
      PAT_OCT_A:   f = -box_sum(0, 0, 0, hw, hh, hd) + box_sum(mw, mh, md, hw, hh, hd);
      PAT_OCT_B:   f = -box_sum(mw, 0, 0, hw, hh, hd) + box_sum(0, mh, md, hw, hh, hd);
      PAT_OCT_C:   f = -box_sum(0, mh, 0, hw, hh, hd) + box_sum(mw, 0, md, hw, hh, hd);
      PAT_OCT_D:   f = -box_sum(0, 0, md, hw, hh, hd) + box_sum(mw, mh, 0, hw, hh, hd);
      default:     f = 0;
    endcase
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    r.feature = f[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    feature_word_t e;
    if (!rst_n) begin
      dim_x = 6'd32;
      dim_y = 6'd32;
      dim_z = 6'd32;
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hfb_pkg::CFG_DIM_X: dim_x = cfg_data;
          hfb_pkg::CFG_DIM_Y: dim_y = cfg_data;
          hfb_pkg::CFG_DIM_Z: dim_z = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_features.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word: feature %0d clipped %0b", $time,
                   $signed(out_tdata[31:0]), out_tdata[32]);
        end else begin
          e = expected_features.pop_front();
          if (out_tdata[31:0] !== e.feature) begin
            fails++;
            $display("%0t: feature mismatch: expected %0d, got %0d", $time,
                     e.feature, $signed(out_tdata[31:0]));
          end
          if (out_tdata[32] !== e.clipped) begin
            fails++;
            $display("%0t: clipped mismatch: expected %0b, got %0b", $time,
                     e.clipped, out_tdata[32]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_LOAD)
          volume[in_tdata[15]][in_tdata[14:10]][in_tdata[9:5]][in_tdata[4:0]] =
            in_tdata[31:16];
        else
          expected_features.push_back(predict_feature(in_tdata));
      end
      pending = expected_features.size();
    end
  end

endmodule

[sim/haar_feature_3d_box_sum_test.sv]
// testbench top: drives loads, queries and extent writes, gives the verdict
module haar_feature_3d_box_sum_test;
  import haar_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CUBE = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = KIND_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = hfb_pkg::CFG_DIM_X;
  logic [5:0]  cfg_data = '0;

  int fails, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int ext_x = 32, ext_y = 32, ext_z = 32;

  always #5 clk = ~clk;

  haar_feature_3d_box_sum i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  haar_feature_3d_box_sum_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  // receiver: random stalls plus a single long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input word_kind_t kind, input logic [4:0] x, input logic [4:0] y,
                           input logic [4:0] z, input logic ch, input logic [15:0] val,
                           input logic [5:0] w, input logic [5:0] h, input logic [5:0] d,
                           input logic [4:0] pat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, pat, d, h, w, val, ch, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  task automatic load_voxel(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z,
                            input logic ch, input logic [15:0] val);
    send_word(KIND_LOAD, x, y, z, ch, val, 6'($urandom_range(63)), 6'($urandom_range(63)),
              6'($urandom_range(63)), 5'($urandom_range(31)));
  endtask

  task automatic query_box(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z,
                           input logic ch, input logic [5:0] w, input logic [5:0] h,
                           input logic [5:0] d, input logic [4:0] pat);
    send_word(KIND_QUERY, x, y, z, ch, 16'($urandom_range(65535)), w, h, d, pat);
  endtask

  // only the loaded cube is read, so an axis wider than it keeps its box inside it
  task automatic pick_axis(input int ext, output logic [4:0] pos, output logic [5:0] sz);
    if (ext <= CUBE) begin
      pos = 5'($urandom_range(31));
      sz  = ($urandom_range(9) == 0) ? 6'd32 : 6'($urandom_range(32));
    end else begin
      pos = 5'($urandom_range(CUBE - 1));
      sz  = 6'($urandom_range(CUBE - int'(pos)));
    end
  endtask

  task automatic random_query();
    logic [4:0] x, y, z;
    logic [5:0] w, h, d;
    pick_axis(ext_x, x, w);
    pick_axis(ext_y, y, h);
    pick_axis(ext_z, z, d);
    query_box(x, y, z, 1'($urandom_range(1)), w, h, d,
              ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(18)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_extents(input int x, input int y, input int z);
    wait_drained();
    repeat (16) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= hfb_pkg::CFG_DIM_X;
    cfg_data <= 6'(x);
    @(negedge clk);
    cfg_index <= hfb_pkg::CFG_DIM_Y;
    cfg_data <= 6'(y);
    @(negedge clk);
    cfg_index <= hfb_pkg::CFG_DIM_Z;
    cfg_data <= 6'(z);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    ext_x = x; ext_y = y; ext_z = z;
  endtask

  initial begin
    int ex [6] = '{32, 6, 1, 6, 5, 32};
    int ey [6] = '{32, 6, 1, 3, 32, 6};
    int ez [6] = '{32, 6, 1, 32, 6, 2};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every voxel of the loaded cube in both channels is written before any query
    set_extents(CUBE, CUBE, CUBE);
    for (int c = 0; c < 2; c++)
      for (int z = 0; z < CUBE; z++)
        for (int y = 0; y < CUBE; y++)
          for (int x = 0; x < CUBE; x++)
            load_voxel(5'(x), 5'(y), 5'(z), 1'(c), 16'($urandom_range(65535)));

    // directed: extreme voxels, every pattern, undefined patterns, box extremes
    load_voxel(0, 0, 0, 0, 16'h8000);
    load_voxel(5, 5, 5, 1, 16'h7fff);
    load_voxel(31, 31, 31, 1, 16'h7fff);
    for (int p = 0; p <= PAT_UNDEF_FIRST; p++)
      query_box(0, 0, 0, 1'(p), 8, 8, 8, 5'(p));
    query_box(0, 0, 0, 0, 7, 5, 4, 5'(PAT_UNDEF_FIRST + 12));
    query_box(31, 31, 31, 1, 32, 32, 32, PAT_HALF_X);
    query_box(0, 0, 0, 0, 0, 0, 0, PAT_OCT_A);
    query_box(0, 0, 0, 1, 32, 32, 32, PAT_THIRD_Z);
    query_box(3, 2, 1, 0, 5, 5, 5, PAT_QUAD_XY);

    for (int ph = 0; ph < 6; ph++) begin
      set_extents(ex[ph], ey[ph], ez[ph]);
      send_idle_pct  = (ph % 4 == 1) ? 53 : (ph % 4 == 3) ? 15 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 53 : (ph % 4 == 3) ? 15 : 0;
      for (int i = 0; i < 105; i++) begin
        if (ph == 2 && i == 40) hold_req = 300;
        if (ph == 3 && i == 90) wait_drained();
        if ($urandom_range(9) < 3)
          load_voxel(5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
                     1'($urandom_range(1)), 16'($urandom_range(65535)));
        else
          random_query();
      end
    end

    wait_drained();
    repeat (50) @(negedge clk);
    $display("covered %0d loads and %0d queries over 7 extent settings", loads_sent,
             queries_sent);
    $display("all 19 patterns plus undefined ones, with stalls and a long output hold-off");
    if (fails == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
